// ----- rtl/bpc_pkg.sv -----
// Shared types and constants of the button press classifier.
// No dependencies; imported by every module of the block.
package bpc_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int BTN_BITS    = 2;
  localparam int CFG_BITS    = 16;

  // Event bits of one button
  localparam logic [3:0] EV_NONE   = 4'b0000;
  localparam logic [3:0] EV_DOWN   = 4'b0001;
  localparam logic [3:0] EV_REPEAT = 4'b0010;
  localparam logic [3:0] EV_SHORT  = 4'b0100;
  localparam logic [3:0] EV_LONG   = 4'b1000;

  // Register reset values
  localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = 16'd25;
  localparam logic [CFG_BITS-1:0] REPEAT_RESET     = 16'd5;

  // Button indexes
  localparam logic [BTN_BITS-1:0] BTN_MODE  = 2'd0;
  localparam logic [BTN_BITS-1:0] BTN_MINUS = 2'd2;

  typedef enum logic [0:0] {
    REG_LONG_PRESS = 1'b0,
    REG_REPEAT     = 1'b1
  } bpc_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_EVAL,
    ST_DONE
  } bpc_state_t;

  typedef struct packed {
    logic mode_pressed;
    logic plus_pressed;
    logic minus_pressed;
  } bpc_sample_t;

  typedef struct packed {
    logic [3:0] mode_events;
    logic [3:0] plus_events;
    logic [3:0] minus_events;
    logic       all_released;
  } bpc_result_t;

  // Status of the serial remainder unit
  typedef struct packed {
    logic done;
    logic rem_zero;
  } bpc_mod_stat_t;

endpackage

// ----- rtl/bpc_serial_mod.sv -----
// Bit-serial restoring remainder: one dividend bit per cycle.
// Depends on bpc_pkg.
module bpc_serial_mod
  import bpc_pkg::*;
#(
  parameter int TICK_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [TICK_BITS-1:0] dividend,
  input  logic [CFG_BITS-1:0]  divisor,
  output bpc_mod_stat_t        stat
);

  localparam int CNT_BITS = $clog2(TICK_BITS);

  logic [TICK_BITS-1:0] dvd;
  logic [CFG_BITS-1:0]  dsr;
  logic [CFG_BITS-1:0]  rem;
  logic [CNT_BITS-1:0]  cnt;
  logic                 busy;
  logic                 done;
  logic [CFG_BITS:0]    trial;
  logic [CFG_BITS:0]    trial_sub;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial     = {rem, dvd[TICK_BITS-1]};
    trial_sub = trial - {1'b0, dsr};
  end

  // Control: stay busy until every dividend bit has been shifted in
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: dividend shifter, remainder and bit counter
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      cnt <= CNT_BITS'(TICK_BITS - 1);
    end else if (busy) begin
      dvd <= dvd << 1;
      cnt <= cnt - 1'b1;
      if (trial >= {1'b0, dsr}) begin
        rem <= trial_sub[CFG_BITS-1:0];
      end else begin
        rem <= trial[CFG_BITS-1:0];
      end
    end
  end

  assign stat.done     = done;
  assign stat.rem_zero = (rem == '0);

endmodule

// ----- rtl/button_press_classifier.sv -----
// Top level of the button press classifier: tick counter, per-button state,
// sequencer and result register. Depends on bpc_pkg and bpc_serial_mod.
//
//  channel   | signals                           | direction
//  ----------+-----------------------------------+----------
//  sample    | sample_valid, sample_stall, sample| in
//  result    | result_valid, result_stall, result| out
//  cfg       | cfg_valid, cfg_ready, cfg_index,  | in
//            | cfg_data                          |
//
// A tick transfer starts three passes, one per button, each made of load, a division
// in the shared bit-serial remainder unit until it reports done, and evaluate.
// The result loads after the last pass, and the next tick can be taken once the
// sequencer is back in idle. The sample side stalls from transfer to result load,
// and longer while the previous result is still stalled. Reset (synchronous)
// clears the tick counter, the held flags and the registers to their defaults.
module button_press_classifier
  import bpc_pkg::*;
#(
  parameter int TICK_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  bpc_sample_t         sample,
  output logic                result_valid,
  input  logic                result_stall,
  output bpc_result_t         result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  bpc_reg_t            cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);

  localparam int CW = (TICK_BITS > CFG_BITS) ? TICK_BITS : CFG_BITS;

  bpc_state_t state, state_next;

  logic [CFG_BITS-1:0]  long_thresh;
  logic [CFG_BITS-1:0]  repeat_gap;
  logic [TICK_BITS-1:0] tick_count;
  logic [TICK_BITS-1:0] press_start [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] held;
  logic [NUM_BUTTONS-1:0] pressed;
  logic [3:0]           events [NUM_BUTTONS];
  logic [BTN_BITS-1:0]  btn;
  logic [CW-1:0]        elapsed;

  logic                 accept;
  logic                 mod_start;
  logic                 load_result;
  logic [TICK_BITS-1:0] elapsed_next;
  logic [CW-1:0]        elapsed_wide;
  logic [CW-1:0]        lp_wide;
  logic [CW-1:0]        excess;
  logic [3:0]           ev_next;
  bpc_mod_stat_t        mod_stat;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_thresh <= LONG_PRESS_RESET;
      repeat_gap  <= REPEAT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LONG_PRESS: long_thresh <= cfg_data;
        REG_REPEAT:     repeat_gap  <= cfg_data;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (sample_valid) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_DIV;
      ST_DIV:  if (mod_stat.done) state_next = ST_EVAL;
      ST_EVAL: state_next = (btn == BTN_MINUS) ? ST_DONE : ST_LOAD;
      ST_DONE: if (!result_valid || !result_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    sample_stall = (state != ST_IDLE);
    mod_start    = (state == ST_LOAD);
    load_result  = (state == ST_DONE) && (!result_valid || !result_stall);
  end

  assign accept = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Elapsed time of the current button and excess over the long threshold
  always_comb begin
    elapsed_next = tick_count - press_start[btn];
    elapsed_wide = CW'(elapsed_next);
    lp_wide      = CW'(long_thresh);
    excess       = elapsed_wide - lp_wide;
  end

  bpc_serial_mod #(
    .TICK_BITS (TICK_BITS)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (excess[TICK_BITS-1:0]),
    .divisor  (repeat_gap),
    .stat     (mod_stat)
  );

  // Classify the current button
  always_comb begin
    ev_next = EV_NONE;
    if (pressed[btn]) begin
      if (!held[btn]) begin
        ev_next = EV_DOWN;
      end else if (elapsed == lp_wide) begin
        ev_next = EV_LONG | EV_REPEAT;
      end else if ((elapsed > lp_wide) && (repeat_gap != '0) && mod_stat.rem_zero) begin
        ev_next = EV_REPEAT;
      end
    end else if (held[btn] && (elapsed < lp_wide)) begin
      ev_next = EV_SHORT;
    end
  end

  // Tick counter, held flags and button index
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      held       <= '0;
      btn        <= BTN_MODE;
    end else begin
      if (accept) begin
        tick_count <= tick_count + 1'b1;
        btn        <= BTN_MODE;
      end
      if (state == ST_EVAL) begin
        held[btn] <= pressed[btn];
        btn       <= btn + 1'b1;
      end
    end
  end

  // Per-tick payload: sampled levels, elapsed time, events, press start
  always_ff @(posedge clk) begin
    if (accept) begin
      pressed <= {sample.minus_pressed, sample.plus_pressed, sample.mode_pressed};
    end
    if (state == ST_LOAD) begin
      elapsed <= elapsed_wide;
    end
    if (state == ST_EVAL) begin
      events[btn] <= ev_next;
      if (pressed[btn] && !held[btn]) begin
        press_start[btn] <= tick_count;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.mode_events  <= events[0];
      result.plus_events  <= events[1];
      result.minus_events <= events[2];
      result.all_released <= ~|held;
    end
  end

endmodule

// ----- rtl/bpc_checker.sv -----
// Port-level checks of the button press classifier, bound to the top level.
// Depends on bpc_pkg.
module bpc_checker
  import bpc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                sample_valid,
  input logic                sample_stall,
  input bpc_sample_t         sample,
  input logic                result_valid,
  input logic                result_stall,
  input bpc_result_t         result,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input bpc_reg_t            cfg_index,
  input logic [CFG_BITS-1:0] cfg_data
);

  // A stalled result stays offered
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // A tick in work blocks the next one
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample taken while a tick is in work");

  // LONG always comes with REPEAT
  a_long_repeat: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!result.mode_events[3] || result.mode_events[1]) &&
                     (!result.plus_events[3] || result.plus_events[1]) &&
                     (!result.minus_events[3] || result.minus_events[1]))
    else $error("LONG without REPEAT");

  // A down or repeat event means a button is still held
  a_held_release: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.mode_events[0] || result.mode_events[1] ||
                     result.plus_events[0] || result.plus_events[1] ||
                     result.minus_events[0] || result.minus_events[1])
    |-> !result.all_released)
    else $error("all_released with a held button");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (.*);
